FILE: hdl/spe_pkg.sv
// shared codes, constants and record types of the shortest path expansion core
package spe_pkg;

   // request actions
   localparam logic [2:0] ACT_WR_COORD    = 3'd0;
   localparam logic [2:0] ACT_WR_NEIGHBOR = 3'd1;
   localparam logic [2:0] ACT_START       = 3'd2;
   localparam logic [2:0] ACT_STEP        = 3'd3;
   localparam logic [2:0] ACT_READ        = 3'd4;

   // response status codes
   localparam logic [1:0] ST_ACCEPT   = 2'd0;
   localparam logic [1:0] ST_EXPANDED = 2'd1;
   localparam logic [1:0] ST_GOAL     = 2'd2;
   localparam logic [1:0] ST_NO_PATH  = 2'd3;

   // search outcome codes
   localparam logic [1:0] OUTCOME_RUNNING = 2'd0;
   localparam logic [1:0] OUTCOME_GOAL    = 2'd2;
   localparam logic [1:0] OUTCOME_NO_PATH = 2'd3;

   // register indexes
   localparam logic CSR_START_NODE = 1'b0;
   localparam logic CSR_GOAL_NODE  = 1'b1;

   localparam logic [31:0] COST_INF    = 32'hFFFF_FFFF;
   localparam logic [31:0] COST_MAX    = 32'hFFFF_FFFE;
   localparam logic [9:0]  PARENT_NONE = 10'd1023;

   // per node search record
   typedef struct packed {
      logic [31:0] cost;
      logic [9:0]  parent;
      logic        visited;
   } node_rec_type;

   // one adjacency slot
   typedef struct packed {
      logic       valid;
      logic [8:0] index;
   } adj_rec_type;

   // square root unit status
   typedef struct packed {
      logic busy;
      logic done;
   } sqrt_status_type;

endpackage

FILE: hdl/spe_ram.sv
// generic single write port, single read port ram with registered read
module spe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/spe_sqrt.sv
// iterative floor square root, one root bit per cycle
module spe_sqrt import spe_pkg::*; #(
   parameter int ROOT_W = 17
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  go,
   input  logic [2*ROOT_W-1:0]   radicand,
   output logic [ROOT_W-1:0]     root,
   output sqrt_status_type       status
);

   localparam int RAD_W = 2 * ROOT_W;
   localparam int REM_W = ROOT_W + 2;
   localparam int CNT_W = $clog2(ROOT_W + 1);

   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [REM_W-1:0]  rem_shift;
   logic [REM_W-1:0]  trial;

   // one digit pair per cycle, restoring form
   always_comb begin
      rem_shift = {rem_ff[ROOT_W-1:0], rad_ff[RAD_W-1 -: 2]};
      trial     = {root_ff, 2'b01};
      rad_in    = rad_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (go) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_shift >= trial) begin
            rem_in  = rem_shift - trial;
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         rad_in = {rad_ff[RAD_W-3:0], 2'b00};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign root        = root_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

FILE: hdl/shortest_path_expansion_step_core.sv
// top level: dijkstra expansion engine over a stored roadmap graph
//
// A request is taken when start is high and busy is low. Every request gives
// exactly one response, shown for one cycle with rsp_valid high; the
// receiver cannot hold it off. The csr_ port sets start and goal nodes and
// is to be written by the user only while the core is idle; the core
// itself does not enforce this. Coordinate and neighbor writes and unknown
// actions answer in the cycle after the request and leave busy low; a read
// in range goes through S_RD_WAIT. A start request sweeps the node record
// memory, one node a cycle. A step request scans all node records through
// the node memory read port, then, unless the lowest open node is the goal
// or none is left, walks the MAX_NEIGHBORS adjacency slots: an empty slot
// passes S_ADJ_RD, S_ADJ_WAIT and S_NEXT, a visited neighbor also S_NB_WAIT,
// others S_MUL, S_SUM, S_SQRT and S_UPD; S_SQRT waits on the iterative
// square root (one root bit a cycle, 17 bits at 16 bit coordinates). A step
// after the search has ended answers no path, or the goal record after a
// goal. After reset the adjacency memory and node records are cleared, one
// slot a cycle, with busy high; csr writes are taken.
module shortest_path_expansion_step_core import spe_pkg::*; #(
   parameter int NODES         = 512,
   parameter int MAX_NEIGHBORS = 10,
   parameter int COORD_BITS    = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_action,
   input  logic [8:0]  req_node_index,
   input  logic [15:0] req_x_coord,
   input  logic [15:0] req_y_coord,
   input  logic [3:0]  req_neighbor_slot,
   input  logic [8:0]  req_neighbor_index,
   input  logic        req_neighbor_valid,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [8:0]  rsp_node_out,
   output logic [31:0] rsp_cost_out,
   output logic [9:0]  rsp_parent_out,
   output logic        rsp_visited_out,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [8:0]  csr_wr_data
);

   localparam int NODE_AW   = $clog2(NODES);
   localparam int ADJ_DEPTH = NODES * MAX_NEIGHBORS;
   localparam int ADJ_AW    = $clog2(ADJ_DEPTH);
   localparam int SLOT_W    = $clog2(MAX_NEIGHBORS + 1);
   localparam int XY_W      = 2 * COORD_BITS;
   localparam int SQ_W      = 2 * COORD_BITS;
   localparam int FULL_W    = SQ_W + 1;
   localparam int SUM_W     = (FULL_W > 64) ? 64 : FULL_W;
   localparam int ROOT_W    = (SUM_W + 1) / 2;
   localparam int RAD_W     = 2 * ROOT_W;
   localparam int NODE_W    = $bits(node_rec_type);
   localparam int ADJ_W     = $bits(adj_rec_type);

   typedef enum logic [3:0] {
      S_RST_CLR, S_IDLE, S_CLR, S_RD_WAIT, S_SCAN, S_SCAN_END, S_DECIDE, S_XY_SEL,
      S_ADJ_RD, S_ADJ_WAIT, S_NB_WAIT, S_MUL, S_SUM, S_SQRT, S_UPD, S_NEXT
   } state_type;

   state_type           state_ff, state_in;
   logic [ADJ_AW-1:0]   sweep_ff, sweep_in;
   logic [8:0]          start_node_ff, start_node_in;
   logic [8:0]          goal_node_ff, goal_node_in;
   logic [1:0]          outcome_ff, outcome_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic [8:0]          rsp_node_ff, rsp_node_in;
   logic [31:0]         rsp_cost_ff, rsp_cost_in;
   logic [9:0]          rsp_parent_ff, rsp_parent_in;
   logic                rsp_visited_ff, rsp_visited_in;
   logic                scan_pend_ff, scan_pend_in;
   logic [NODE_AW-1:0]  scan_addr_ff, scan_addr_in;
   logic [31:0]         best_ff, best_in;
   logic [NODE_AW-1:0]  sel_ff, sel_in;
   logic [9:0]          par_ff, par_in;
   logic [ADJ_AW-1:0]   base_ff, base_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [NODE_AW-1:0]  nb_ff, nb_in;
   logic [31:0]         nbcost_ff, nbcost_in;
   logic [COORD_BITS-1:0] selx_ff, selx_in, sely_ff, sely_in;
   logic [COORD_BITS-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [SQ_W-1:0]     sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [31:0]         cand_ff, cand_in;
   logic                rd_end_ff, rd_end_in;
   logic [8:0]          rd_node_ff, rd_node_in;

   logic                accept;
   logic                idx_ok, slot_ok, goal_ok;
   logic                xy_we;
   logic [NODE_AW-1:0]  xy_wr_addr, xy_rd_addr;
   logic [XY_W-1:0]     xy_wr_data, xy_rd_data;
   logic                adj_we;
   logic [ADJ_AW-1:0]   adj_wr_addr, adj_rd_addr;
   adj_rec_type         adj_wr_data, adj_rd;
   logic [ADJ_W-1:0]    adj_rd_data;
   logic                node_we;
   logic [NODE_AW-1:0]  node_wr_addr, node_rd_addr;
   node_rec_type        node_wr_data, node_rd;
   logic [NODE_W-1:0]   node_rd_data;
   logic [COORD_BITS-1:0] nbx, nby;
   logic [FULL_W-1:0]   sq_full;
   logic [RAD_W-1:0]    sq_rad;
   logic                sq_go;
   logic [ROOT_W-1:0]   sq_root;
   sqrt_status_type     sq_status;
   logic [32:0]         cost_sum;

   assign accept  = start && (state_ff == S_IDLE);
   assign idx_ok  = 32'(req_node_index) < NODES;
   assign slot_ok = 32'(req_neighbor_slot) < MAX_NEIGHBORS;
   assign goal_ok = 32'(goal_node_ff) < NODES;
   assign adj_rd  = adj_rec_type'(adj_rd_data);
   assign node_rd = node_rec_type'(node_rd_data);
   assign nbx     = xy_rd_data[XY_W-1:COORD_BITS];
   assign nby     = xy_rd_data[COORD_BITS-1:0];

   // coordinate memory ports
   always_comb begin
      xy_we      = accept && (req_action == ACT_WR_COORD) && idx_ok;
      xy_wr_addr = NODE_AW'(req_node_index);
      xy_wr_data = {COORD_BITS'(req_x_coord), COORD_BITS'(req_y_coord)};
      xy_rd_addr = (state_ff == S_DECIDE) ? sel_ff : NODE_AW'(adj_rd.index);
   end

   // adjacency memory ports, cleared after reset
   always_comb begin
      adj_we            = 1'b0;
      adj_wr_addr       = sweep_ff;
      adj_wr_data.valid = 1'b0;
      adj_wr_data.index = '0;
      if (state_ff == S_RST_CLR) begin
         adj_we = 1'b1;
      end else if (accept && (req_action == ACT_WR_NEIGHBOR) && idx_ok && slot_ok) begin
         adj_we      = 1'b1;
         adj_wr_addr = ADJ_AW'(32'(req_node_index) * MAX_NEIGHBORS
                               + 32'(req_neighbor_slot));
         if (req_neighbor_valid) begin
            adj_wr_data.valid = 1'b1;
            adj_wr_data.index = req_neighbor_index;
         end
      end
      adj_rd_addr = base_ff + ADJ_AW'(slot_ff);
   end

   // node record memory ports
   always_comb begin
      node_we              = 1'b0;
      node_wr_addr         = NODE_AW'(sweep_ff);
      node_wr_data.cost    = COST_INF;
      node_wr_data.parent  = PARENT_NONE;
      node_wr_data.visited = 1'b0;
      case (state_ff)
         S_RST_CLR: begin
            node_we = 32'(sweep_ff) < NODES;
         end
         S_CLR: begin
            node_we = 1'b1;
            if (32'(start_node_ff) == 32'(sweep_ff)) begin
               node_wr_data.cost = '0;
            end
         end
         S_DECIDE: begin
            node_we              = (best_ff != COST_INF) &&
                                   (32'(sel_ff) != 32'(goal_node_ff));
            node_wr_addr         = sel_ff;
            node_wr_data.cost    = best_ff;
            node_wr_data.parent  = par_ff;
            node_wr_data.visited = 1'b1;
         end
         S_UPD: begin
            node_we             = cand_ff < nbcost_ff;
            node_wr_addr        = nb_ff;
            node_wr_data.cost   = cand_ff;
            node_wr_data.parent = 10'(sel_ff);
         end
         default: begin
         end
      endcase

      node_rd_addr = '0;
      case (state_ff)
         S_IDLE:     node_rd_addr = (req_action == ACT_STEP) ? NODE_AW'(goal_node_ff)
                                                            : NODE_AW'(req_node_index);
         S_SCAN:     node_rd_addr = NODE_AW'(sweep_ff);
         S_ADJ_WAIT: node_rd_addr = NODE_AW'(adj_rd.index);
         default:    node_rd_addr = '0;
      endcase
   end

   // distance: sum of squares, saturated to the root unit width
   always_comb begin
      sq_full  = FULL_W'(sqx_ff) + FULL_W'(sqy_ff);
      sq_rad   = RAD_W'(sq_full);
      if ((FULL_W > RAD_W) && sq_full[FULL_W-1]) begin
         sq_rad = '1;
      end
      sq_go    = (state_ff == S_SUM);
      cost_sum = 33'(best_ff) + 33'(sq_root);
   end

   // next state and registered outputs
   always_comb begin
      state_in       = state_ff;
      sweep_in       = sweep_ff;
      start_node_in  = start_node_ff;
      goal_node_in   = goal_node_ff;
      outcome_in     = outcome_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_node_in    = rsp_node_ff;
      rsp_cost_in    = rsp_cost_ff;
      rsp_parent_in  = rsp_parent_ff;
      rsp_visited_in = rsp_visited_ff;
      scan_pend_in   = (state_ff == S_SCAN);
      scan_addr_in   = NODE_AW'(sweep_ff);
      best_in        = best_ff;
      sel_in         = sel_ff;
      par_in         = par_ff;
      base_in        = base_ff;
      slot_in        = slot_ff;
      nb_in          = nb_ff;
      nbcost_in      = nbcost_ff;
      selx_in        = selx_ff;
      sely_in        = sely_ff;
      dx_in          = dx_ff;
      dy_in          = dy_ff;
      sqx_in         = sqx_ff;
      sqy_in         = sqy_ff;
      cand_in        = cand_ff;
      rd_end_in      = rd_end_ff;
      rd_node_in     = rd_node_ff;

      // register writes
      if (csr_wr_en) begin
         case (csr_index)
            CSR_START_NODE: start_node_in = csr_wr_data;
            CSR_GOAL_NODE:  goal_node_in  = csr_wr_data;
            default: begin
            end
         endcase
      end

      // minimum search, one record a cycle, first lowest wins
      if (scan_pend_ff && !node_rd.visited && (node_rd.cost < best_ff)) begin
         best_in = node_rd.cost;
         sel_in  = scan_addr_ff;
         par_in  = node_rd.parent;
      end

      case (state_ff)
         S_RST_CLR: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == ADJ_AW'(ADJ_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               rsp_status_in  = ST_ACCEPT;
               rsp_node_in    = '0;
               rsp_cost_in    = '0;
               rsp_parent_in  = '0;
               rsp_visited_in = 1'b0;
               case (req_action)
                  ACT_START: begin
                     state_in   = S_CLR;
                     sweep_in   = '0;
                     outcome_in = OUTCOME_RUNNING;
                  end
                  ACT_STEP: begin
                     if (outcome_ff == OUTCOME_RUNNING) begin
                        state_in = S_SCAN;
                        sweep_in = '0;
                        best_in  = COST_INF;
                        sel_in   = '0;
                        par_in   = PARENT_NONE;
                     end else if ((outcome_ff == OUTCOME_GOAL) && goal_ok) begin
                        state_in   = S_RD_WAIT;
                        rd_end_in  = 1'b1;
                        rd_node_in = goal_node_ff;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_NO_PATH;
                        rsp_cost_in   = COST_INF;
                        rsp_parent_in = PARENT_NONE;
                     end
                  end
                  ACT_READ: begin
                     if (idx_ok) begin
                        state_in   = S_RD_WAIT;
                        rd_end_in  = 1'b0;
                        rd_node_in = req_node_index;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_node_in   = req_node_index;
                        rsp_cost_in   = COST_INF;
                        rsp_parent_in = PARENT_NONE;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_CLR: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == ADJ_AW'(NODES - 1)) begin
               state_in       = S_IDLE;
               rsp_valid_in   = 1'b1;
               rsp_status_in  = ST_ACCEPT;
               rsp_node_in    = '0;
               rsp_cost_in    = '0;
               rsp_parent_in  = '0;
               rsp_visited_in = 1'b0;
            end
         end
         S_RD_WAIT: begin
            state_in       = S_IDLE;
            rsp_valid_in   = 1'b1;
            rsp_status_in  = rd_end_ff ? ST_GOAL : ST_ACCEPT;
            rsp_node_in    = rd_node_ff;
            rsp_cost_in    = node_rd.cost;
            rsp_parent_in  = node_rd.parent;
            rsp_visited_in = node_rd.visited;
         end
         S_SCAN: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == ADJ_AW'(NODES - 1)) begin
               state_in = S_SCAN_END;
            end
         end
         S_SCAN_END: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (best_ff == COST_INF) begin
               state_in       = S_IDLE;
               outcome_in     = OUTCOME_NO_PATH;
               rsp_valid_in   = 1'b1;
               rsp_status_in  = ST_NO_PATH;
               rsp_node_in    = '0;
               rsp_cost_in    = COST_INF;
               rsp_parent_in  = PARENT_NONE;
               rsp_visited_in = 1'b0;
            end else if (32'(sel_ff) == 32'(goal_node_ff)) begin
               state_in       = S_IDLE;
               outcome_in     = OUTCOME_GOAL;
               rsp_valid_in   = 1'b1;
               rsp_status_in  = ST_GOAL;
               rsp_node_in    = goal_node_ff;
               rsp_cost_in    = best_ff;
               rsp_parent_in  = par_ff;
               rsp_visited_in = 1'b0;
            end else begin
               state_in = S_XY_SEL;
               base_in  = ADJ_AW'(32'(sel_ff) * MAX_NEIGHBORS);
               slot_in  = '0;
            end
         end
         S_XY_SEL: begin
            selx_in  = nbx;
            sely_in  = nby;
            state_in = S_ADJ_RD;
         end
         S_ADJ_RD: begin
            state_in = S_ADJ_WAIT;
         end
         S_ADJ_WAIT: begin
            if (adj_rd.valid && (32'(adj_rd.index) < NODES)) begin
               nb_in    = NODE_AW'(adj_rd.index);
               state_in = S_NB_WAIT;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_NB_WAIT: begin
            if (node_rd.visited) begin
               state_in = S_NEXT;
            end else begin
               nbcost_in = node_rd.cost;
               dx_in     = (selx_ff > nbx) ? selx_ff - nbx : nbx - selx_ff;
               dy_in     = (sely_ff > nby) ? sely_ff - nby : nby - sely_ff;
               state_in  = S_MUL;
            end
         end
         S_MUL: begin
            sqx_in   = SQ_W'(dx_ff) * SQ_W'(dx_ff);
            sqy_in   = SQ_W'(dy_ff) * SQ_W'(dy_ff);
            state_in = S_SUM;
         end
         S_SUM: begin
            state_in = S_SQRT;
         end
         S_SQRT: begin
            if (sq_status.done) begin
               cand_in  = (cost_sum > 33'(COST_MAX)) ? COST_MAX : cost_sum[31:0];
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            state_in = S_NEXT;
         end
         S_NEXT: begin
            if (slot_ff == SLOT_W'(MAX_NEIGHBORS - 1)) begin
               state_in       = S_IDLE;
               rsp_valid_in   = 1'b1;
               rsp_status_in  = ST_EXPANDED;
               rsp_node_in    = 9'(sel_ff);
               rsp_cost_in    = best_ff;
               rsp_parent_in  = par_ff;
               rsp_visited_in = 1'b1;
            end else begin
               slot_in  = slot_ff + 1'b1;
               state_in = S_ADJ_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_RST_CLR;
         sweep_ff      <= '0;
         start_node_ff <= 9'd0;
         goal_node_ff  <= 9'd1;
         outcome_ff    <= OUTCOME_RUNNING;
         rsp_valid_ff  <= 1'b0;
         scan_pend_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_ff      <= sweep_in;
         start_node_ff <= start_node_in;
         goal_node_ff  <= goal_node_in;
         outcome_ff    <= outcome_in;
         rsp_valid_ff  <= rsp_valid_in;
         scan_pend_ff  <= scan_pend_in;
      end
      rsp_status_ff  <= rsp_status_in;
      rsp_node_ff    <= rsp_node_in;
      rsp_cost_ff    <= rsp_cost_in;
      rsp_parent_ff  <= rsp_parent_in;
      rsp_visited_ff <= rsp_visited_in;
      scan_addr_ff   <= scan_addr_in;
      best_ff        <= best_in;
      sel_ff         <= sel_in;
      par_ff         <= par_in;
      base_ff        <= base_in;
      slot_ff        <= slot_in;
      nb_ff          <= nb_in;
      nbcost_ff      <= nbcost_in;
      selx_ff        <= selx_in;
      sely_ff        <= sely_in;
      dx_ff          <= dx_in;
      dy_ff          <= dy_in;
      sqx_ff         <= sqx_in;
      sqy_ff         <= sqy_in;
      cand_ff        <= cand_in;
      rd_end_ff      <= rd_end_in;
      rd_node_ff     <= rd_node_in;
   end

   // memories
   spe_ram #(.WIDTH(XY_W), .DEPTH(NODES)) u_xy_ram (
      .clock   (clock),
      .wr_en   (xy_we),
      .wr_addr (xy_wr_addr),
      .wr_data (xy_wr_data),
      .rd_addr (xy_rd_addr),
      .rd_data (xy_rd_data)
   );

   spe_ram #(.WIDTH(ADJ_W), .DEPTH(ADJ_DEPTH)) u_adj_ram (
      .clock   (clock),
      .wr_en   (adj_we),
      .wr_addr (adj_wr_addr),
      .wr_data (adj_wr_data),
      .rd_addr (adj_rd_addr),
      .rd_data (adj_rd_data)
   );

   spe_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_node_ram (
      .clock   (clock),
      .wr_en   (node_we),
      .wr_addr (node_wr_addr),
      .wr_data (node_wr_data),
      .rd_addr (node_rd_addr),
      .rd_data (node_rd_data)
   );

   // edge length unit
   spe_sqrt #(.ROOT_W(ROOT_W)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .go       (sq_go),
      .radicand (sq_rad),
      .root     (sq_root),
      .status   (sq_status)
   );

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_node_out    = rsp_node_ff;
   assign rsp_cost_out    = rsp_cost_ff;
   assign rsp_parent_out  = rsp_parent_ff;
   assign rsp_visited_out = rsp_visited_ff;

   // a no path answer only comes from an ended search
   a_no_path_ended: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == ST_NO_PATH) |-> outcome_ff != OUTCOME_RUNNING)
      else $error("no path response while search running");

   // an expanded node is reported visited with a finite cost
   a_expanded_finite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == ST_EXPANDED) |->
         rsp_visited_ff && (rsp_cost_ff != COST_INF))
      else $error("expanded node without finite cost");

   // the root unit finishes only while the sequencer waits for it
   a_sqrt_done_wait: assert property (@(posedge clock) disable iff (reset)
      sq_status.done |-> state_ff == S_SQRT)
      else $error("square root finished outside its wait state");

   // relaxation never rewrites the expanded node
   a_relax_not_self: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPD) && node_we |-> nb_ff != sel_ff)
      else $error("relaxation wrote the expanded node");

endmodule
